// ===== sv/tlc_pkg.sv =====
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types, constants and helpers of the two-level cache tag store.
// ----------------------------------------------------------------------------
package tlc_pkg;

  localparam int CNT_W = 40;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [1:0] POL_INCL = 2'd0;
  localparam logic [1:0] POL_EXCL = 2'd1;

  // back part to front part
  typedef struct packed {
    logic pop;
    logic clearing;
  } tlc_ctl_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ===== sv/tlc_ram.sv =====
// ----------------------------------------------------------------------------
// tlc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/tlc_front.sv =====
// ----------------------------------------------------------------------------
// tlc_front
// Accepts access words and holds them in a two-entry queue for the back part.
// ----------------------------------------------------------------------------
module tlc_front
  import tlc_pkg::*;
#(
  parameter int ADDR_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 req_type,
  input  logic [ADDR_BITS-1:0] address,
  output logic                 busy,
  input  tlc_ctl_t             ctl,
  output logic                 q_valid,
  output logic                 q_type,
  output logic [ADDR_BITS-1:0] q_addr
);

  logic                 qt [2];
  logic [ADDR_BITS-1:0] qa [2];
  logic                 wp, rp;
  logic [1:0]           cnt;
  logic                 push, pop;

  assign busy    = (cnt == 2'd2) || ctl.clearing;
  assign push    = start && !busy;
  assign pop     = ctl.pop && (cnt != 2'd0);
  assign q_valid = (cnt != 2'd0);
  assign q_type  = qt[rp];
  assign q_addr  = qa[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      qt[wp] <= req_type;
      qa[wp] <= address;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      if (push && !pop) cnt <= cnt + 2'd1;
      else if (pop && !push) cnt <= cnt - 2'd1;
    end
  end

endmodule

// ===== sv/tlc_back.sv =====
// ----------------------------------------------------------------------------
// tlc_back
// Carries out lookups, LRU way scans, fills and invalidations on the tag RAMs.
// ----------------------------------------------------------------------------
module tlc_back
  import tlc_pkg::*;
#(
  parameter int ADDR_BITS  = 48,
  parameter int L2_SETS    = 1024,
  parameter int L2_WAYS    = 8,
  parameter int L3_SETS    = 2048,
  parameter int L3_WAYS    = 16,
  parameter int LINE_BYTES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           policy,
  input  logic                 q_valid,
  input  logic                 q_type,
  input  logic [ADDR_BITS-1:0] q_addr,
  output tlc_ctl_t             ctl,
  output logic                 done,
  output logic                 counted,
  output logic                 l2_hit,
  output logic                 l3_hit,
  output logic                 back_invalidated,
  output logic                 l2_victim_moved,
  output logic [CNT_W-1:0]     access_count,
  output logic [CNT_W-1:0]     l2_hit_count,
  output logic [CNT_W-1:0]     l2_miss_count,
  output logic [CNT_W-1:0]     l3_hit_count,
  output logic [CNT_W-1:0]     l3_miss_count
);

  localparam int OB   = $clog2(LINE_BYTES + 1) - 1;
  localparam int IB2  = $clog2(L2_SETS + 1) - 1;
  localparam int IB3  = $clog2(L3_SETS + 1) - 1;
  localparam int R2   = 1 << IB2;
  localparam int R3   = 1 << IB3;
  localparam int T2   = ADDR_BITS - OB - IB2;
  localparam int T3   = ADDR_BITS - OB - IB3;
  localparam int E2   = 1 + T2 + CNT_W;
  localparam int E3   = 1 + T3 + CNT_W;
  localparam int RW2  = L2_WAYS * E2;
  localparam int RW3  = L3_WAYS * E3;
  localparam int WB2  = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
  localparam int WB3  = (L3_WAYS > 1) ? $clog2(L3_WAYS) : 1;
  localparam int MAXW = (L2_WAYS > L3_WAYS) ? L2_WAYS : L3_WAYS;
  localparam int SWB  = $clog2(MAXW + 1);
  localparam int RM   = (R2 > R3) ? R2 : R3;
  localparam int CB   = $clog2(RM + 1);

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_RWAIT   = 4'd2;
  localparam logic [3:0] S_L2_LOOK = 4'd3;
  localparam logic [3:0] S_L3_LOOK = 4'd4;
  localparam logic [3:0] S_SCAN    = 4'd5;
  localparam logic [3:0] S_FILL    = 4'd6;
  localparam logic [3:0] S_W2      = 4'd7;
  localparam logic [3:0] S_W3      = 4'd8;
  localparam logic [3:0] S_V3_LOOK = 4'd9;
  localparam logic [3:0] S_INV2    = 4'd10;
  localparam logic [3:0] S_RELOAD2 = 4'd11;

  localparam logic [2:0] ST_HIT2  = 3'd0;
  localparam logic [2:0] ST_F2    = 3'd1;
  localparam logic [2:0] ST_F3A   = 3'd2;
  localparam logic [2:0] ST_F3V   = 3'd3;
  localparam logic [2:0] ST_INV   = 3'd4;
  localparam logic [2:0] ST_LOOK3 = 3'd5;

  logic [3:0] state, ret;
  logic [2:0] step;
  logic [CB-1:0] clr;

  logic [ADDR_BITS-1:0] cur, fa, vaddr;
  logic vv;
  logic [IB2-1:0] ra2;
  logic [IB3-1:0] ra3;

  // working rows
  logic           r2_v [L2_WAYS];
  logic [T2-1:0]  r2_t [L2_WAYS];
  logic [CNT_W-1:0] r2_s [L2_WAYS];
  logic           r3_v [L3_WAYS];
  logic [T3-1:0]  r3_t [L3_WAYS];
  logic [CNT_W-1:0] r3_s [L3_WAYS];

  logic [RW2-1:0] rdata2, wdata2, pack2;
  logic [RW3-1:0] rdata3, wdata3, pack3;
  logic [IB2-1:0] waddr2;
  logic [IB3-1:0] waddr3;
  logic we2, we3;

  logic           rd2_v [L2_WAYS];
  logic [T2-1:0]  rd2_t [L2_WAYS];
  logic [CNT_W-1:0] rd2_s [L2_WAYS];
  logic           rd3_v [L3_WAYS];
  logic [T3-1:0]  rd3_t [L3_WAYS];
  logic [CNT_W-1:0] rd3_s [L3_WAYS];

  logic [T2-1:0]  cmp2;
  logic           hit2, hit3;
  logic [WB2-1:0] hw2;
  logic [WB3-1:0] hw3;

  // way scan
  logic           lvl;
  logic [SWB-1:0] sc, pick, pick_n;
  logic           fnd, fnd_n;
  logic [CNT_W-1:0] best, best_n;
  logic           el_v;
  logic [CNT_W-1:0] el_s;
  logic           sc_last;
  logic [WB2-1:0] p2;
  logic [WB3-1:0] p3;

  logic [CNT_W-1:0] acc, h2c, m2c, h3c, m3c;

  tlc_ram #(.WIDTH(RW2), .DEPTH(R2)) u_l2 (
    .clk(clk), .we(we2), .waddr(waddr2), .wdata(wdata2), .raddr(ra2), .rdata(rdata2)
  );

  tlc_ram #(.WIDTH(RW3), .DEPTH(R3)) u_l3 (
    .clk(clk), .we(we3), .waddr(waddr3), .wdata(wdata3), .raddr(ra3), .rdata(rdata3)
  );

  always_comb begin
    for (int w = 0; w < L2_WAYS; w++) begin
      rd2_v[w] = rdata2[w*E2 + E2 - 1];
      rd2_t[w] = rdata2[w*E2 + CNT_W +: T2];
      rd2_s[w] = rdata2[w*E2 +: CNT_W];
      pack2[w*E2 +: E2] = {r2_v[w], r2_t[w], r2_s[w]};
    end
    for (int w = 0; w < L3_WAYS; w++) begin
      rd3_v[w] = rdata3[w*E3 + E3 - 1];
      rd3_t[w] = rdata3[w*E3 + CNT_W +: T3];
      rd3_s[w] = rdata3[w*E3 +: CNT_W];
      pack3[w*E3 +: E3] = {r3_v[w], r3_t[w], r3_s[w]};
    end
  end

  assign we2    = ((state == S_CLR) && (clr < CB'(R2))) || (state == S_W2);
  assign we3    = ((state == S_CLR) && (clr < CB'(R3))) || (state == S_W3);
  assign waddr2 = (state == S_CLR) ? clr[IB2-1:0] : ra2;
  assign waddr3 = (state == S_CLR) ? clr[IB3-1:0] : ra3;
  assign wdata2 = (state == S_CLR) ? '0 : pack2;
  assign wdata3 = (state == S_CLR) ? '0 : pack3;

  // lowest matching valid way
  assign cmp2 = (state == S_INV2) ? fa[ADDR_BITS-1 -: T2] : cur[ADDR_BITS-1 -: T2];

  always_comb begin
    hit2 = 1'b0;
    hw2  = '0;
    for (int w = L2_WAYS - 1; w >= 0; w--) begin
      if (rd2_v[w] && (rd2_t[w] == cmp2)) begin
        hit2 = 1'b1;
        hw2  = WB2'(w);
      end
    end
    hit3 = 1'b0;
    hw3  = '0;
    for (int w = L3_WAYS - 1; w >= 0; w--) begin
      if (rd3_v[w] && (rd3_t[w] == cur[ADDR_BITS-1 -: T3])) begin
        hit3 = 1'b1;
        hw3  = WB3'(w);
      end
    end
  end

  // one way per cycle: first invalid way, else oldest stamp, ties to lowest
  always_comb begin
    el_v    = lvl ? r3_v[sc[WB3-1:0]] : r2_v[sc[WB2-1:0]];
    el_s    = lvl ? r3_s[sc[WB3-1:0]] : r2_s[sc[WB2-1:0]];
    sc_last = lvl ? (sc == SWB'(L3_WAYS - 1)) : (sc == SWB'(L2_WAYS - 1));
    pick_n  = pick;
    best_n  = best;
    fnd_n   = fnd;
    if (!fnd) begin
      if (!el_v) begin
        pick_n = sc;
        fnd_n  = 1'b1;
      end else if ((sc == '0) || (el_s < best)) begin
        pick_n = sc;
        best_n = el_s;
      end
    end
  end

  assign p2 = pick[WB2-1:0];
  assign p3 = pick[WB3-1:0];

  assign ctl.pop      = (state == S_IDLE) && q_valid;
  assign ctl.clearing = (state == S_CLR);

  assign access_count  = acc;
  assign l2_hit_count  = h2c;
  assign l2_miss_count = m2c;
  assign l3_hit_count  = h3c;
  assign l3_miss_count = m3c;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLR;
      clr              <= '0;
      done             <= 1'b0;
      counted          <= 1'b0;
      l2_hit           <= 1'b0;
      l3_hit           <= 1'b0;
      back_invalidated <= 1'b0;
      l2_victim_moved  <= 1'b0;
      acc              <= '0;
      h2c              <= '0;
      m2c              <= '0;
      h3c              <= '0;
      m3c              <= '0;
      ret              <= S_IDLE;
      step             <= ST_HIT2;
      lvl              <= 1'b0;
      sc               <= '0;
      pick             <= '0;
      fnd              <= 1'b0;
      ra2              <= '0;
      ra3              <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr <= clr + CB'(1);
          if (clr == CB'(RM - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            counted          <= q_type;
            l2_hit           <= 1'b0;
            l3_hit           <= 1'b0;
            back_invalidated <= 1'b0;
            l2_victim_moved  <= 1'b0;
            cur              <= q_addr;
            if (q_type) begin
              acc   <= sat_inc(acc);
              ra2   <= q_addr[OB +: IB2];
              ret   <= S_L2_LOOK;
              state <= S_RWAIT;
            end else begin
              done <= 1'b1;
            end
          end
        end
        S_RWAIT: begin
          state <= ret;
        end
        S_L2_LOOK: begin
          for (int w = 0; w < L2_WAYS; w++) begin
            r2_v[w] <= rd2_v[w];
            r2_t[w] <= rd2_t[w];
            r2_s[w] <= (hit2 && (hw2 == WB2'(w))) ? acc : rd2_s[w];
          end
          if (hit2) begin
            l2_hit <= 1'b1;
            h2c    <= sat_inc(h2c);
            step   <= ST_HIT2;
            state  <= S_W2;
          end else begin
            m2c   <= sat_inc(m2c);
            ra3   <= cur[OB +: IB3];
            ret   <= S_L3_LOOK;
            state <= S_RWAIT;
          end
        end
        S_L3_LOOK: begin
          for (int w = 0; w < L3_WAYS; w++) begin
            r3_t[w] <= rd3_t[w];
            r3_s[w] <= (hit3 && (hw3 == WB3'(w))) ? acc : rd3_s[w];
            // exclusive: the hit line leaves L3
            r3_v[w] <= (hit3 && (hw3 == WB3'(w)) && (policy == POL_EXCL)) ? 1'b0 : rd3_v[w];
          end
          fa   <= cur;
          sc   <= '0;
          fnd  <= 1'b0;
          pick <= '0;
          best <= '0;
          if (hit3) begin
            l3_hit <= 1'b1;
            h3c    <= sat_inc(h3c);
            step   <= ST_LOOK3;
            state  <= S_W3;
          end else begin
            m3c <= sat_inc(m3c);
            if (policy == POL_EXCL) begin
              lvl  <= 1'b0;
              step <= ST_F2;
            end else begin
              lvl  <= 1'b1;
              step <= ST_F3A;
            end
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          pick <= pick_n;
          best <= best_n;
          fnd  <= fnd_n;
          sc   <= sc + SWB'(1);
          if (sc_last) state <= S_FILL;
        end
        S_FILL: begin
          if (lvl) begin
            vv       <= r3_v[p3];
            vaddr    <= {r3_t[p3], ra3, {OB{1'b0}}};
            r3_v[p3] <= 1'b1;
            r3_t[p3] <= fa[ADDR_BITS-1 -: T3];
            r3_s[p3] <= acc;
            state    <= S_W3;
          end else begin
            vv       <= r2_v[p2];
            vaddr    <= {r2_t[p2], ra2, {OB{1'b0}}};
            r2_v[p2] <= 1'b1;
            r2_t[p2] <= cur[ADDR_BITS-1 -: T2];
            r2_s[p2] <= acc;
            state    <= S_W2;
          end
        end
        S_W2: begin
          case (step)
            ST_F2: begin
              if ((policy == POL_EXCL) && vv) begin
                l2_victim_moved <= 1'b1;
                fa    <= vaddr;
                ra3   <= vaddr[OB +: IB3];
                ret   <= S_V3_LOOK;
                state <= S_RWAIT;
              end else begin
                done  <= 1'b1;
                state <= S_IDLE;
              end
            end
            ST_INV: begin
              ra2   <= cur[OB +: IB2];
              ret   <= S_RELOAD2;
              state <= S_RWAIT;
            end
            default: begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          endcase
        end
        S_W3: begin
          sc   <= '0;
          fnd  <= 1'b0;
          pick <= '0;
          best <= '0;
          case (step)
            ST_F3A: begin
              if (vv && (policy == POL_INCL)) begin
                fa    <= vaddr;
                ra2   <= vaddr[OB +: IB2];
                ret   <= S_INV2;
                state <= S_RWAIT;
              end else begin
                lvl   <= 1'b0;
                step  <= ST_F2;
                state <= S_SCAN;
              end
            end
            ST_F3V: begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
            default: begin
              lvl   <= 1'b0;
              step  <= ST_F2;
              state <= S_SCAN;
            end
          endcase
        end
        S_V3_LOOK: begin
          for (int w = 0; w < L3_WAYS; w++) begin
            r3_v[w] <= rd3_v[w];
            r3_t[w] <= rd3_t[w];
            r3_s[w] <= rd3_s[w];
          end
          sc    <= '0;
          fnd   <= 1'b0;
          pick  <= '0;
          best  <= '0;
          lvl   <= 1'b1;
          step  <= ST_F3V;
          state <= S_SCAN;
        end
        S_INV2: begin
          for (int w = 0; w < L2_WAYS; w++) begin
            r2_v[w] <= (hit2 && (hw2 == WB2'(w))) ? 1'b0 : rd2_v[w];
            r2_t[w] <= rd2_t[w];
            r2_s[w] <= rd2_s[w];
          end
          if (hit2) begin
            back_invalidated <= 1'b1;
            step  <= ST_INV;
            state <= S_W2;
          end else begin
            ra2   <= cur[OB +: IB2];
            ret   <= S_RELOAD2;
            state <= S_RWAIT;
          end
        end
        S_RELOAD2: begin
          for (int w = 0; w < L2_WAYS; w++) begin
            r2_v[w] <= rd2_v[w];
            r2_t[w] <= rd2_t[w];
            r2_s[w] <= rd2_s[w];
          end
          sc    <= '0;
          fnd   <= 1'b0;
          pick  <= '0;
          best  <= '0;
          lvl   <= 1'b0;
          step  <= ST_F2;
          state <= S_SCAN;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/two_level_lru_cache_inclusion.sv =====
// ----------------------------------------------------------------------------
// two_level_lru_cache_inclusion
// Tag store of an L2 and an L3 cache with LRU replacement and a selectable
// inclusion policy (inclusive, exclusive, non-inclusive non-exclusive).
// ----------------------------------------------------------------------------
// After reset both tag RAMs are cleared one row a cycle, up to the larger row
// count of the two levels, while busy stays high. A word is taken when
// start is high and busy is low; a two-entry queue holds words ahead of the
// sequencer. Each word gives exactly one result, shown for one cycle with
// done high; the receiver cannot stall it. An ignored word is answered from
// the idle state with no tag RAM access. A miss takes one row read-modify-write
// per tag RAM access plus one way per cycle for each LRU victim scan, more of
// both when L3 is filled, a victim moves or a line is back-invalidated. Each
// level has one tag RAM with one read and one write port, and the victim scan
// goes way by way.
module two_level_lru_cache_inclusion
  import tlc_pkg::*;
#(
  parameter int ADDR_BITS  = 48,
  parameter int L2_SETS    = 1024,
  parameter int L2_WAYS    = 8,
  parameter int L3_SETS    = 2048,
  parameter int L3_WAYS    = 16,
  parameter int LINE_BYTES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 start,
  output logic                 busy,
  input  logic                 req_type,
  input  logic [ADDR_BITS-1:0] address,
  output logic                 done,
  output logic                 counted,
  output logic                 l2_hit,
  output logic                 l3_hit,
  output logic                 back_invalidated,
  output logic                 l2_victim_moved,
  output logic [CNT_W-1:0]     access_count,
  output logic [CNT_W-1:0]     l2_hit_count,
  output logic [CNT_W-1:0]     l2_miss_count,
  output logic [CNT_W-1:0]     l3_hit_count,
  output logic [CNT_W-1:0]     l3_miss_count
);

  logic [1:0]           policy;
  tlc_ctl_t             ctl;
  logic                 q_valid, q_type;
  logic [ADDR_BITS-1:0] q_addr;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {30'd0, policy} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POL_INCL;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      policy <= pwdata[1:0];
    end
  end

  tlc_front #(.ADDR_BITS(ADDR_BITS)) u_front (
    .clk(clk), .rst(rst), .start(start), .req_type(req_type), .address(address),
    .busy(busy), .ctl(ctl), .q_valid(q_valid), .q_type(q_type), .q_addr(q_addr)
  );

  tlc_back #(
    .ADDR_BITS(ADDR_BITS), .L2_SETS(L2_SETS), .L2_WAYS(L2_WAYS),
    .L3_SETS(L3_SETS), .L3_WAYS(L3_WAYS), .LINE_BYTES(LINE_BYTES)
  ) u_back (
    .clk(clk), .rst(rst), .policy(policy),
    .q_valid(q_valid), .q_type(q_type), .q_addr(q_addr), .ctl(ctl),
    .done(done), .counted(counted), .l2_hit(l2_hit), .l3_hit(l3_hit),
    .back_invalidated(back_invalidated), .l2_victim_moved(l2_victim_moved),
    .access_count(access_count), .l2_hit_count(l2_hit_count),
    .l2_miss_count(l2_miss_count), .l3_hit_count(l3_hit_count),
    .l3_miss_count(l3_miss_count)
  );

endmodule

// ===== test/tlc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tlc_checker
// Watches the access and result ports of the two-level tag store, keeps its
// own copy of both tag levels, and checks every result word against the
// oldest prediction in order.
// ----------------------------------------------------------------------------
module tlc_checker
  import tlc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  input  logic             pready,
  input  logic             start,
  input  logic             busy,
  input  logic             req_type,
  input  logic [47:0]      address,
  input  logic             done,
  input  logic             counted,
  input  logic             l2_hit,
  input  logic             l3_hit,
  input  logic             back_invalidated,
  input  logic             l2_victim_moved,
  input  logic [CNT_W-1:0] access_count,
  input  logic [CNT_W-1:0] l2_hit_count,
  input  logic [CNT_W-1:0] l2_miss_count,
  input  logic [CNT_W-1:0] l3_hit_count,
  input  logic [CNT_W-1:0] l3_miss_count,
  output int               pending,
  output int               fails
);

  localparam logic [2:0] REG_POLICY = 3'd0;
  localparam int OFS_BITS = 6;

  typedef struct packed {
    logic             counted;
    logic             l2_hit;
    logic             l3_hit;
    logic             binv;
    logic             moved;
    logic [CNT_W-1:0] acc;
    logic [CNT_W-1:0] h2;
    logic [CNT_W-1:0] m2;
    logic [CNT_W-1:0] h3;
    logic [CNT_W-1:0] m3;
  } lookup_result_t;

  // level 0 is L2, level 1 is L3
  bit               line_vld [2][32768];
  logic [47:0]      line_tag [2][32768];
  logic [CNT_W-1:0] line_stp [2][32768];
  logic [1:0]       policy;
  logic [CNT_W-1:0] n_acc, n_h2, n_m2, n_h3, n_m3;
  lookup_result_t   result_q[$];

  function automatic int idx_bits(int lv);
    return lv ? 11 : 10;
  endfunction

  function automatic int ways_of(int lv);
    return lv ? 16 : 8;
  endfunction

  function automatic int set_base(int lv, logic [47:0] a);
    return int'(((a >> OFS_BITS) & ((48'd1 << idx_bits(lv)) - 48'd1)) * ways_of(lv));
  endfunction

  function automatic logic [47:0] tag_of(int lv, logic [47:0] a);
    return a >> (OFS_BITS + idx_bits(lv));
  endfunction

  function automatic bit probe(int lv, logic [47:0] a, logic [CNT_W-1:0] now);
    int b;
    b = set_base(lv, a);
    for (int w = 0; w < ways_of(lv); w++) begin
      if (line_vld[lv][b+w] && line_tag[lv][b+w] == tag_of(lv, a)) begin
        line_stp[lv][b+w] = now;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic bit drop_line(int lv, logic [47:0] a);
    int b;
    b = set_base(lv, a);
    for (int w = 0; w < ways_of(lv); w++) begin
      if (line_vld[lv][b+w] && line_tag[lv][b+w] == tag_of(lv, a)) begin
        line_vld[lv][b+w] = 0;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic bit place_line(int lv, logic [47:0] a, logic [CNT_W-1:0] now,
                                    output logic [47:0] victim);
    int b, pick;
    bit found, had;
    b = set_base(lv, a);
    pick = 0;
    found = 0;
    victim = '0;
    for (int w = 0; w < ways_of(lv) && !found; w++) begin
      if (!line_vld[lv][b+w]) begin
        pick = w;
        found = 1;
      end
    end
    if (!found) begin
      for (int w = 1; w < ways_of(lv); w++)
        if (line_stp[lv][b+w] < line_stp[lv][b+pick]) pick = w;
    end
    had = line_vld[lv][b+pick];
    if (had)
      victim = ((line_tag[lv][b+pick] << idx_bits(lv)) | 48'(b / ways_of(lv))) << OFS_BITS;
    line_tag[lv][b+pick] = tag_of(lv, a);
    line_vld[lv][b+pick] = 1;
    line_stp[lv][b+pick] = now;
    return had;
  endfunction

  function automatic lookup_result_t run_access(logic kind, logic [47:0] a);
    lookup_result_t r;
    logic [47:0] vic, spare;
    r = '0;
    if (kind) begin
      r.counted = 1;
      n_acc = sat_inc(n_acc);
      if (probe(0, a, n_acc)) begin
        r.l2_hit = 1;
        n_h2 = sat_inc(n_h2);
      end else begin
        n_m2 = sat_inc(n_m2);
        if (probe(1, a, n_acc)) begin
          r.l3_hit = 1;
          n_h3 = sat_inc(n_h3);
        end else begin
          n_m3 = sat_inc(n_m3);
        end
        if (policy == POL_EXCL) begin
          if (r.l3_hit) void'(drop_line(1, a));
          if (place_line(0, a, n_acc, vic)) begin
            void'(place_line(1, vic, n_acc, spare));
            r.moved = 1;
          end
        end else begin
          if (!r.l3_hit && place_line(1, a, n_acc, vic) && policy == POL_INCL)
            r.binv = drop_line(0, vic);
          void'(place_line(0, a, n_acc, vic));
        end
      end
    end
    r.acc = n_acc;
    r.h2 = n_h2;
    r.m2 = n_m2;
    r.h3 = n_h3;
    r.m3 = n_m3;
    return r;
  endfunction

  initial begin
    for (int lv = 0; lv < 2; lv++)
      for (int i = 0; i < 32768; i++) line_vld[lv][i] = 0;
    fails = 0;
  end

  assign pending = result_q.size();

  always @(posedge clk) begin
    lookup_result_t got, want;
    if (rst) begin
      policy <= POL_INCL;
      n_acc = '0; n_h2 = '0; n_m2 = '0; n_h3 = '0; n_m3 = '0;
      result_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_POLICY)
        policy <= pwdata[1:0];
      if (start && !busy)
        result_q.push_back(run_access(req_type, address));
      if (done) begin
        got = '{counted, l2_hit, l3_hit, back_invalidated, l2_victim_moved,
                access_count, l2_hit_count, l2_miss_count, l3_hit_count,
                l3_miss_count};
        if (result_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result word %h", got);
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: flags c/h2/h3/bi/mv exp %b%b%b%b%b got %b%b%b%b%b\n",
                       want.counted, want.l2_hit, want.l3_hit, want.binv, want.moved,
                       got.counted, got.l2_hit, got.l3_hit, got.binv, got.moved,
                       "  counts exp %h %h %h %h %h got %h %h %h %h %h",
                       want.acc, want.h2, want.m2, want.h3, want.m3,
                       got.acc, got.h2, got.m2, got.h3, got.m3);
          end
        end
      end
    end
  end

endmodule

// ===== test/two_level_lru_cache_inclusion_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_level_lru_cache_inclusion_tb
// Drives directed and random trace accesses into the tag store under every
// inclusion policy, with sender gaps, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module two_level_lru_cache_inclusion_tb;
  import tlc_pkg::*;

  localparam logic [2:0] REG_POLICY = 3'd0;
  localparam logic [1:0] POL_NINE = 2'd2;
  localparam logic [1:0] POL_NINE_ALIAS = 2'd3;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 0, req_type = 0;
  logic [47:0] address = '0;
  logic busy, done, counted, l2_hit, l3_hit, back_invalidated, l2_victim_moved;
  logic [CNT_W-1:0] access_count, l2_hit_count, l2_miss_count, l3_hit_count, l3_miss_count;
  int pending, fails, gap_pct;

  always #5 clk = ~clk;

  two_level_lru_cache_inclusion u_top (.*);
  tlc_checker u_chk (.*);

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  task automatic reg_write(input logic [2:0] a, input logic [31:0] d);
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= a; pwdata <= d;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // one word, held until taken, then an optional gap
  task automatic send_word(input logic kind, input logic [47:0] a);
    start <= 1; req_type <= kind; address <= a;
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < gap_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // mostly a few hot sets with a small tag pool, so lines hit and get evicted
  function automatic logic [47:0] pick_addr();
    logic [30:0] t;
    int k;
    if ($urandom_range(99) < 20) return 48'({$urandom, $urandom});
    k = $urandom_range(0, 39);
    t = 31'(k) ^ ((k % 3 == 0) ? 31'h7fff_ffc0 : 31'h0);
    return {t, 11'($urandom_range(0, 3)), 6'($urandom)};
  endfunction

  initial begin
    logic [1:0] pols[8] = '{POL_INCL, POL_EXCL, POL_NINE, POL_NINE_ALIAS,
                            POL_EXCL, POL_INCL, POL_NINE, POL_EXCL};
    gap_pct = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    while (busy) @(posedge clk);
    reg_write(REG_POLICY, POL_INCL);
    // directed: extremes, ignored words, repeats, then overflow of one set
    send_word(1, '0);
    send_word(1, '0);
    send_word(1, '1);
    send_word(0, '1);
    send_word(1, '1);
    send_word(0, '0);
    for (int i = 0; i < 19; i++) send_word(1, {31'(i), 11'd5, 6'd0});
    start <= 0;
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      reg_write(REG_POLICY, pols[ph]);
      gap_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 45 : 35;
      for (int i = 0; i < 125; i++)
        send_word($urandom_range(99) < 90, pick_addr());
      start <= 0;
      drain();
    end
    if (fails == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tlc_pkg.sv
sv/tlc_ram.sv
sv/tlc_front.sv
sv/tlc_back.sv
sv/two_level_lru_cache_inclusion.sv
test/tlc_checker.sv
test/two_level_lru_cache_inclusion_tb.sv
